### design/wavhp_pkg.sv
package wavhp_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned HALF_W   = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SKIP_W   = 33;
  localparam int unsigned FIDX_W   = 4;
  localparam int unsigned OUT_DATA_W = 152;

  localparam logic [WORD_W-1:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [WORD_W-1:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [WORD_W-1:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [WORD_W-1:0] TAG_DATA = 32'h6174_6164;

  localparam logic [WORD_W-1:0] FILE_SIZE_RST = 32'd0;
  localparam logic [WORD_W-1:0] MIN_RATE_RST  = 32'd5000;
  localparam logic [WORD_W-1:0] MAX_RATE_RST  = 32'd44100;

  localparam logic [HALF_W-1:0] PCM_CODE      = 16'd1;
  localparam logic [HALF_W-1:0] STEREO_CHANS  = 16'd2;
  localparam logic [HALF_W-1:0] SAMPLE_BITS16 = 16'd16;
  localparam logic [HALF_W-1:0] FRAME_ALIGN   = 16'd4;
  localparam logic [WORD_W-1:0] FMT_MIN_SIZE  = 32'd16;

  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_HEAD = 3'd1,
    PH_FMT  = 3'd2,
    PH_SKIP = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE    = 2'd0,
    KIND_END     = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_WAVE  = 3'd1,
    ST_FMT_SHORT = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_UNSUPP    = 3'd4,
    ST_BEYOND    = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILE_SIZE = 2'd0,
    REG_MIN_RATE  = 2'd1,
    REG_MAX_RATE  = 2'd2,
    REG_NONE      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [WORD_W-1:0] file_len;
    logic [WORD_W-1:0] min_rate;
    logic [WORD_W-1:0] max_rate;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] data_length;
    logic [WORD_W-1:0] data_start;
    logic [HALF_W-1:0] frame_bytes;
    logic [WORD_W-1:0] bytes_per_sec;
    logic [WORD_W-1:0] rate_hz;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

### design/wavhp_core.sv
module wavhp_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_valid,
  input  logic [wavhp_pkg::KIND_W-1:0]  step_kind,
  input  logic [wavhp_pkg::BYTE_W-1:0]  step_byte,
  input  wavhp_pkg::cfg_t               cfg,
  output logic                          emit,
  output wavhp_pkg::result_t            result
);
  import wavhp_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [WORD_W-1:0]   pos_r, pos_nxt;
  logic [FIDX_W-1:0]   fidx_r, fidx_nxt;
  logic [WORD_W-1:0]   shift_r, shift_nxt;
  logic [WORD_W-1:0]   tag_r, tag_nxt;
  logic [SKIP_W-1:0]   skip_r, skip_nxt;
  logic                fseen_r, fseen_nxt;
  logic                dseen_r, dseen_nxt;
  logic [HALF_W-1:0]   enc_r, enc_nxt;
  logic [HALF_W-1:0]   chan_r, chan_nxt;
  logic [WORD_W-1:0]   rate_r, rate_nxt;
  logic [WORD_W-1:0]   brate_r, brate_nxt;
  logic [HALF_W-1:0]   align_r, align_nxt;
  logic [HALF_W-1:0]   bits_r, bits_nxt;
  logic [WORD_W-1:0]   poff_r, poff_nxt;
  logic [WORD_W-1:0]   psize_r, psize_nxt;

  logic                emit_c;
  status_t             status_c;
  status_t             verdict;
  logic [WORD_W-1:0]   sw;
  logic [WORD_W-1:0]   room;

  // align is 4 here, so rate * align must fit in 32 bits exactly
  always_comb begin
    room = cfg.file_len - poff_nxt;
    if (enc_nxt != PCM_CODE || chan_nxt != STEREO_CHANS || bits_nxt != SAMPLE_BITS16 ||
        align_nxt != FRAME_ALIGN || rate_nxt < cfg.min_rate || rate_nxt > cfg.max_rate ||
        rate_nxt[WORD_W-1:WORD_W-2] != 2'b00 ||
        brate_nxt != {rate_nxt[WORD_W-3:0], 2'b00} ||
        psize_nxt == '0 || psize_nxt[1:0] != 2'b00) begin
      verdict = ST_UNSUPP;
    end else if (poff_nxt > cfg.file_len || psize_nxt > room) begin
      verdict = ST_BEYOND;
    end else begin
      verdict = ST_OK;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    fidx_nxt  = fidx_r;
    shift_nxt = shift_r;
    tag_nxt   = tag_r;
    skip_nxt  = skip_r;
    fseen_nxt = fseen_r;
    dseen_nxt = dseen_r;
    enc_nxt   = enc_r;
    chan_nxt  = chan_r;
    rate_nxt  = rate_r;
    brate_nxt = brate_r;
    align_nxt = align_r;
    bits_nxt  = bits_r;
    poff_nxt  = poff_r;
    psize_nxt = psize_r;
    emit_c    = 1'b0;
    status_c  = ST_OK;
    sw        = {step_byte, shift_r[WORD_W-1:BYTE_W]};

    if (step_valid) begin
      if (kind_t'(step_kind) == KIND_RESTART) begin
        phase_nxt = PH_RIFF;
        pos_nxt   = '0;
        fidx_nxt  = '0;
        shift_nxt = '0;
        tag_nxt   = '0;
        skip_nxt  = '0;
        fseen_nxt = 1'b0;
        dseen_nxt = 1'b0;
        enc_nxt   = '0;
        chan_nxt  = '0;
        rate_nxt  = '0;
        brate_nxt = '0;
        align_nxt = '0;
        bits_nxt  = '0;
        poff_nxt  = '0;
        psize_nxt = '0;
      end else if (phase_r == PH_DONE || kind_t'(step_kind) == KIND_UNUSED) begin
        phase_nxt = phase_r;
      end else if (kind_t'(step_kind) == KIND_END) begin
        emit_c    = 1'b1;
        status_c  = ST_TRUNC;
      end else begin
        if (pos_r != '1) pos_nxt = pos_r + 1'b1;
        shift_nxt = sw;
        unique case (phase_r)
          PH_RIFF: begin
            if (fidx_r == 4'd3) tag_nxt = sw;
            if (fidx_r == 4'd11) begin
              fidx_nxt = '0;
              if (tag_r != TAG_RIFF || sw != TAG_WAVE) begin
                emit_c   = 1'b1;
                status_c = ST_NOT_WAVE;
              end else begin
                phase_nxt = PH_HEAD;
              end
            end else begin
              fidx_nxt = fidx_r + 1'b1;
            end
          end
          PH_HEAD: begin
            if (fidx_r == 4'd3) tag_nxt = sw;
            if (fidx_r != 4'd7) begin
              fidx_nxt = fidx_r + 1'b1;
            end else begin
              fidx_nxt = '0;
              if (tag_r == TAG_FMT && !fseen_r) begin
                if (sw < FMT_MIN_SIZE) begin
                  emit_c   = 1'b1;
                  status_c = ST_FMT_SHORT;
                end else begin
                  skip_nxt  = {1'b0, sw} - {1'b0, FMT_MIN_SIZE} + {{WORD_W{1'b0}}, sw[0]};
                  phase_nxt = PH_FMT;
                end
              end else begin
                skip_nxt = {1'b0, sw} + {{WORD_W{1'b0}}, sw[0]};
                if (tag_r == TAG_DATA && !dseen_r) begin
                  poff_nxt  = pos_nxt;
                  psize_nxt = sw;
                  dseen_nxt = 1'b1;
                  if (fseen_r) begin
                    emit_c   = 1'b1;
                    status_c = verdict;
                  end
                end
                if (!emit_c) phase_nxt = (skip_nxt != '0) ? PH_SKIP : PH_HEAD;
              end
            end
          end
          PH_FMT: begin
            unique case (fidx_r)
              4'd1:    enc_nxt   = sw[WORD_W-1:HALF_W];
              4'd3:    chan_nxt  = sw[WORD_W-1:HALF_W];
              4'd7:    rate_nxt  = sw;
              4'd11:   brate_nxt = sw;
              4'd13:   align_nxt = sw[WORD_W-1:HALF_W];
              4'd15:   bits_nxt  = sw[WORD_W-1:HALF_W];
              default: enc_nxt   = enc_r;
            endcase
            if (fidx_r != 4'd15) begin
              fidx_nxt = fidx_r + 1'b1;
            end else begin
              fseen_nxt = 1'b1;
              if (dseen_r) begin
                emit_c   = 1'b1;
                status_c = verdict;
              end else begin
                fidx_nxt  = '0;
                phase_nxt = (skip_r != '0) ? PH_SKIP : PH_HEAD;
              end
            end
          end
          PH_SKIP: begin
            if (skip_r != '0) skip_nxt = skip_r - 1'b1;
            if (skip_nxt == '0) begin
              fidx_nxt  = '0;
              phase_nxt = PH_HEAD;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
      if (emit_c) phase_nxt = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
      pos_r   <= '0;
      fidx_r  <= '0;
      shift_r <= '0;
      tag_r   <= '0;
      skip_r  <= '0;
      fseen_r <= 1'b0;
      dseen_r <= 1'b0;
      enc_r   <= '0;
      chan_r  <= '0;
      rate_r  <= '0;
      brate_r <= '0;
      align_r <= '0;
      bits_r  <= '0;
      poff_r  <= '0;
      psize_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      fidx_r  <= fidx_nxt;
      shift_r <= shift_nxt;
      tag_r   <= tag_nxt;
      skip_r  <= skip_nxt;
      fseen_r <= fseen_nxt;
      dseen_r <= dseen_nxt;
      enc_r   <= enc_nxt;
      chan_r  <= chan_nxt;
      rate_r  <= rate_nxt;
      brate_r <= brate_nxt;
      align_r <= align_nxt;
      bits_r  <= bits_nxt;
      poff_r  <= poff_nxt;
      psize_r <= psize_nxt;
    end
  end

  always_comb begin
    emit          = emit_c;
    result        = '0;
    result.status = status_c;
    if (status_c == ST_OK) begin
      result.rate_hz       = rate_nxt;
      result.bytes_per_sec = brate_nxt;
      result.frame_bytes   = align_nxt;
      result.data_start    = poff_nxt;
      result.data_length   = psize_nxt;
    end
  end

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> phase_r == PH_DONE)
    else $error("verdict given but parser not finished");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_valid && kind_t'(step_kind) == KIND_RESTART |=> phase_r == PH_RIFF && pos_r == '0)
    else $error("restart did not clear parse state");

  a_ok_frame: assert property (@(posedge clk) disable iff (!rst_n)
    emit && result.status == ST_OK |-> result.frame_bytes == FRAME_ALIGN && result.data_length != '0)
    else $error("ok verdict with bad frame or length");

  a_head_index: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEAD |-> fidx_r <= 4'd7)
    else $error("chunk header index out of range");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE && step_valid && kind_t'(step_kind) != KIND_RESTART |-> !emit)
    else $error("second verdict without restart");

endmodule

### design/wav_header_parser_unit.sv
// RIFF/WAVE header parser. Feed a WAV file one byte per transfer on the
// input stream (tuser kind 0), then an end marker (kind 1) if the file ends;
// kind 2 restarts for a new file. One verdict is sent per file: status plus
// sample rate, byte rate, frame size, data offset and data length (all zero
// unless status is ok). One input transfer is taken every cycle while the
// input does not stall; a byte goes through an input register and the parse
// step, and the verdict it decides is registered in the result register. The
// input stalls only while a verdict sits in the result register unaccepted.
// Configuration registers: 0 file size, 1 minimum rate, 2 maximum rate;
// write them only while idle.
module wav_header_parser_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [wavhp_pkg::BYTE_W-1:0]      in_tdata,   // byte_value
  input  logic [wavhp_pkg::KIND_W-1:0]      in_tuser,   // kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status, rate_hz, bytes_per_sec, frame_bytes, data_start, data_length, zero pad
  output logic [wavhp_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wavhp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wavhp_pkg::WORD_W-1:0]      cfg_data
);
  import wavhp_pkg::*;

  localparam int unsigned RES_W = $bits(result_t);

  logic                 s_valid_r;
  logic [KIND_W-1:0]    s_kind_r;
  logic [BYTE_W-1:0]    s_byte_r;
  logic                 adv;
  logic                 emit;
  result_t              res;
  cfg_t                 cfg_r;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_res_r;

  assign adv       = s_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s_valid_r || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tready) begin
      s_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s_kind_r <= in_tuser;
      s_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.file_len <= FILE_SIZE_RST;
      cfg_r.min_rate <= MIN_RATE_RST;
      cfg_r.max_rate <= MAX_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_FILE_SIZE: cfg_r.file_len <= cfg_data;
        REG_MIN_RATE:  cfg_r.min_rate <= cfg_data;
        REG_MAX_RATE:  cfg_r.max_rate <= cfg_data;
        REG_NONE:      cfg_r.file_len <= cfg_r.file_len;
      endcase
    end
  end

  wavhp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (adv),
    .step_kind  (s_kind_r),
    .step_byte  (s_byte_r),
    .cfg        (cfg_r),
    .emit       (emit),
    .result     (res)
  );

  assign out_valid_nxt = (out_valid_r && !out_tready) || (adv && emit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, out_res_r};

endmodule
